### sv/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds in a cycle, so b holds in the same cycle
`define ASSERT_SAME(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("assertion failed");

// a holds in a cycle, so b holds in the next cycle
`define ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("assertion failed");

`endif

### sv/ace_pkg.sv
// types, codes and defaults of the address-resolution cache
package ace_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int SLOT_W      = 6;
    localparam logic [31:0] TIMEOUT_RST = 32'd10000;

    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_LEARN  = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] ip_addr;
        logic [47:0] hw_addr;
    } ace_in_t;

    typedef struct packed {
        logic              hit;
        logic [47:0]       mac_out;
        logic [SLOT_W-1:0] slot;
        logic              replaced;
    } ace_out_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] stamp;
    } ace_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } ace_state_t;

endpackage

### sv/ace_mem.sv
// entry store: one read and one write port, valid bits make unwritten entries read as zero
module ace_mem
    import ace_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    rd_en,
    input  logic [IDX_W-1:0]        rd_addr,
    output ace_entry_t              rd_data,
    input  logic                    wr_en,
    input  logic [IDX_W-1:0]        wr_addr,
    input  ace_entry_t              wr_data
);
    ace_entry_t         mem [ENTRIES];
    logic [ENTRIES-1:0] vld_reg;
    ace_entry_t         rdat_reg;
    logic               rvld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdat_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rvld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rvld_reg ? rdat_reg : '0;

endmodule

### sv/ace_ctrl.sv
// scan sequencer: timeout and clock registers, match and oldest search, write-back, result register
module ace_ctrl
    import ace_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ace_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output ace_out_t         m_data,
    input  logic             cfg_valid,
    input  logic [31:0]      cfg_data,
    output logic             rd_en,
    output logic [IDX_W-1:0] rd_addr,
    input  ace_entry_t       rd_data,
    output logic             wr_en,
    output logic [IDX_W-1:0] wr_addr,
    output ace_entry_t       wr_data
);
    localparam logic [IDX_W:0] CNT_END = (IDX_W+1)'(ENTRIES);

    ace_state_t       state_reg, state_next;
    logic [31:0]      timeout_reg;
    logic [31:0]      now_reg, now_next;
    ace_in_t          req_reg, req_next;
    logic [IDX_W:0]   cnt_reg, cnt_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] fidx_reg, fidx_next;
    logic [47:0]      fmac_reg, fmac_next;
    logic [31:0]      btime_reg, btime_next;
    logic [IDX_W-1:0] bidx_reg, bidx_next;
    ace_out_t         res_reg, res_next;
    ace_out_t         out_reg, out_next;
    logic             ovld_reg, ovld_next;

    logic [31:0]         age;
    logic                fresh;
    logic [IDX_W-1:0]    sel_idx;
    logic [IDX_W+SLOT_W-1:0] slot_ext;

    assign age      = now_reg - rd_data.stamp;
    assign fresh    = (rd_data.ip == req_reg.ip_addr) && (age < timeout_reg);
    assign sel_idx  = found_reg ? fidx_reg : bidx_reg;
    assign slot_ext = {{SLOT_W{1'b0}}, sel_idx};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            timeout_reg <= TIMEOUT_RST;
            now_reg     <= '0;
            pend_reg    <= 1'b0;
            ovld_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            now_reg   <= now_next;
            pend_reg  <= pend_next;
            ovld_reg  <= ovld_next;
            if (cfg_valid) begin
                timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        cnt_reg   <= cnt_next;
        pidx_reg  <= pidx_next;
        found_reg <= found_next;
        fidx_reg  <= fidx_next;
        fmac_reg  <= fmac_next;
        btime_reg <= btime_next;
        bidx_reg  <= bidx_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    always_comb begin
        state_next = state_reg;
        now_next   = now_reg;
        req_next   = req_reg;
        cnt_next   = cnt_reg;
        pend_next  = 1'b0;
        pidx_next  = pidx_reg;
        found_next = found_reg;
        fidx_next  = fidx_reg;
        fmac_next  = fmac_reg;
        btime_next = btime_reg;
        bidx_next  = bidx_reg;
        res_next   = res_reg;
        out_next   = out_reg;
        ovld_next  = ovld_reg && !m_ready;
        rd_en      = 1'b0;
        rd_addr    = cnt_reg[IDX_W-1:0];
        wr_en      = 1'b0;
        wr_addr    = sel_idx;
        wr_data.ip    = req_reg.ip_addr;
        wr_data.mac   = req_reg.hw_addr;
        wr_data.stamp = now_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    res_next   = '0;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    case (s_data.req_type)
                        REQ_TICK: begin
                            now_next   = now_reg + 32'd1;
                            state_next = ST_DONE;
                        end
                        REQ_LEARN, REQ_LOOKUP: begin
                            state_next = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                rd_en = (cnt_reg < CNT_END);
                if (rd_en) begin
                    cnt_next  = cnt_reg + {{IDX_W{1'b0}}, 1'b1};
                    pend_next = 1'b1;
                    pidx_next = cnt_reg[IDX_W-1:0];
                end
                if (pend_reg) begin
                    if (fresh && !found_reg) begin
                        found_next = 1'b1;
                        fidx_next  = pidx_reg;
                        fmac_next  = rd_data.mac;
                    end
                    // strict compare keeps the lowest slot among equal stamps
                    if (pidx_reg == '0 || rd_data.stamp < btime_reg) begin
                        btime_next = rd_data.stamp;
                        bidx_next  = pidx_reg;
                    end
                end
                if (!rd_en && !pend_reg) begin
                    if (req_reg.req_type == REQ_LEARN) begin
                        state_next = ST_WRITE;
                    end else begin
                        res_next.hit      = found_reg;
                        res_next.mac_out  = found_reg ? fmac_reg : '0;
                        res_next.slot     = found_reg ? slot_ext[SLOT_W-1:0] : '0;
                        res_next.replaced = 1'b0;
                        state_next        = ST_DONE;
                    end
                end
            end
            ST_WRITE: begin
                wr_en             = 1'b1;
                res_next.hit      = found_reg;
                res_next.mac_out  = '0;
                res_next.slot     = slot_ext[SLOT_W-1:0];
                res_next.replaced = !found_reg;
                state_next        = ST_DONE;
            end
            ST_DONE: begin
                if (!ovld_reg || m_ready) begin
                    out_next   = res_reg;
                    ovld_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = ovld_reg;
    assign m_data  = out_reg;

endmodule

### sv/arp_cache_age_evict_top.sv
// steps from acceptance to the result: tick or unused code go straight to the done state,
//   lookup scans every entry first, learn scans and then writes; done waits while a stalled result holds the output
// throughput: one item at a time; lookup and learn walk every entry, one a cycle, through
//   the single read port, so the next beat is taken only once the result is registered
// reset: synchronous, active low; timeout to 10000, clock to zero, every entry reads
//   as zero through per-entry valid bits, so no clearing pass is needed
module arp_cache_age_evict_top
    import ace_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  ace_in_t     s_data,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output ace_out_t    m_data,
    // timeout register write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // entry store ports
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    ace_entry_t       rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    ace_entry_t       wr_data;

    // the register is taken at any time; configuration is to come only while idle, which the block does not enforce
    assign cfg_ready = 1'b1;

    // sequencer: reads each entry in turn, keeps the first fresh match and
    // the lowest slot with the smallest stamp, then writes back on learn
    ace_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // address, mac and stamp of every slot, with a registered read
    ace_mem #(
        .ENTRIES (ENTRIES)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

### sv/ace_checker.sv
// port-level checker for the address-resolution cache, bound to the top level
`include "assert_macros.svh"

module ace_checker
    import ace_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input ace_out_t m_data
);

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // one item at a time: busy right after a beat is taken
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // a mac is only returned on a hit
    `ASSERT_SAME(a_mac_needs_hit, aclk, aresetn, m_valid && (m_data.mac_out != '0), m_data.hit)

    // an eviction never reports a hit
    `ASSERT_SAME(a_replace_no_hit, aclk, aresetn, m_valid && m_data.replaced, !m_data.hit)

endmodule

bind arp_cache_age_evict_top ace_checker u_ace_checker (.*);
